/* hdl/signed_int_to_decimal_ascii_top_defines.svh */
// Assertion macros used by the top-level block for its concurrent checks.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define SITOA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Non-overlapping implication: the consequent must hold in the next cycle.
`define SITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sitoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int VALUE_WIDTH = 32;
  // Decimal digits of 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2).
  localparam int DIGITS      = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int BCD_W       = DIGITS * 4;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int DCNT_W      = $clog2(DIGITS + 1);
  localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] MINUS_SIGN = 8'h2D;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIGN,
    B_DIGIT
  } back_state_t;

endpackage

/* hdl/signed_int_to_decimal_ascii_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts signed two's complement integers to their decimal ASCII text.
// ----------------------------------------------------------------------------
// Each value accepted on the slave side comes out on the master side as a run
// of ASCII characters, most significant first: an optional '-', then the
// digits without leading zeros ('0' alone for zero), with tlast set on the
// final digit. The input stage and a two-entry queue take new values while
// the engine works. The engine loads a job, runs its VALUE_WIDTH magnitude
// bits through the bit-serial binary to BCD shifter, sends the sign for
// negative values, then steps through all DIGITS digit positions, where
// leading zeros are skipped at one per cycle and each character needs
// one transfer.
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top
  import sitoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [7:0] ascii_char
  output logic               m_tlast    // last_char
);

  logic front_valid;
  logic front_ready;
  job_t front_job;
  logic back_valid;
  logic back_ready;
  job_t back_job;
  logic digit_fire;
  logic out_last;
  logic char_is_digit;
  logic engine_waiting;

  sitoa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  sitoa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_job    (front_job),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_job   (back_job)
  );

  sitoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  assign digit_fire     = m_tvalid && m_tready && !m_tlast && (m_tdata != MINUS_SIGN);
  assign out_last       = m_tvalid && m_tlast;
  assign char_is_digit  = (m_tdata >= DIGIT_ZERO) && (m_tdata <= DIGIT_NINE);
  assign engine_waiting = back_ready && !back_valid;

  // Once a digit has gone out, the remaining digits follow with no gap.
  `SITOA_ASSERT_NEXT(a_digits_contiguous, digit_fire, m_tvalid, "digit run broken by a gap")
  // A run always ends on a digit, never on the sign.
  `SITOA_ASSERT_SAME(a_last_is_digit, out_last, char_is_digit, "last character is not a digit")
  // While the engine waits for a job, the output stays quiet.
  `SITOA_ASSERT_SAME(a_pop_valid, engine_waiting, !m_tvalid, "engine idle yet presenting output")

endmodule

/* hdl/sitoa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_front
// Input stage: accepts values, splits them into sign and magnitude, and holds
// the result in a register until the job queue takes it.
// ----------------------------------------------------------------------------
module sitoa_front
  import sitoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  logic                   held;
  job_t                   job_reg;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   neg;

  assign raw      = s_tdata[VALUE_WIDTH-1:0];
  assign neg      = raw[VALUE_WIDTH-1];
  assign s_tready = !held || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  // The most negative value negates to itself, which is its exact magnitude.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      job_reg.neg <= neg;
      job_reg.mag <= neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    end
  end

  assign job_valid = held;
  assign job       = job_reg;

endmodule

/* hdl/sitoa_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_queue
// Two-entry job queue between the input stage and the conversion engine.
// ----------------------------------------------------------------------------
module sitoa_queue
  import sitoa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

/* hdl/sitoa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_back
// Conversion engine: bit-serial binary to BCD (shift and add 3), then emits
// the sign of a negative value and the digits one character per transfer, skipping leading zeros.
// ----------------------------------------------------------------------------
module sitoa_back
  import sitoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] ascii_char
  output logic       m_tlast    // last_char
);

  back_state_t            state;
  back_state_t            state_next;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [BCD_W-1:0]       bcd;
  logic [CNT_W-1:0]       cnt;
  logic [DCNT_W-1:0]      dcnt;
  logic                   started;
  logic [3:0]             top_digit;
  logic                   skip;
  logic                   out_fire;
  logic                   shift_digit;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                              input logic bit_in);
    logic [BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[BCD_W-2:0], bit_in};
  endfunction

  assign top_digit = bcd[BCD_W-1 -: 4];
  // A leading zero is dropped, but the units digit always goes out.
  assign skip      = (state == B_DIGIT) && !started && (top_digit == 4'd0)
                     && (dcnt != DCNT_W'(1));
  assign out_fire  = m_tvalid && m_tready;
  assign shift_digit = skip || ((state == B_DIGIT) && out_fire);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = B_CONV;
        end
      end
      B_CONV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = neg ? B_SIGN : B_DIGIT;
        end
      end
      B_SIGN: begin
        if (m_tready) begin
          state_next = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (out_fire && (dcnt == DCNT_W'(1))) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    job_ready = 1'b0;
    m_tvalid  = 1'b0;
    m_tdata   = DIGIT_ZERO;
    m_tlast   = 1'b0;
    case (state)
      B_IDLE: begin
        job_ready = 1'b1;
      end
      B_SIGN: begin
        m_tvalid = 1'b1;
        m_tdata  = MINUS_SIGN;
      end
      B_DIGIT: begin
        m_tvalid = !skip;
        m_tdata  = DIGIT_ZERO + {4'd0, top_digit};
        m_tlast  = (dcnt == DCNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (state == B_IDLE) begin
      started <= 1'b0;
    end else if ((state == B_DIGIT) && out_fire) begin
      started <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          neg   <= job.neg;
          shreg <= job.mag;
          bcd   <= '0;
          cnt   <= CNT_W'(VALUE_WIDTH);
        end
      end
      B_CONV: begin
        bcd   <= dabble(bcd, shreg[VALUE_WIDTH-1]);
        shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
        dcnt  <= DCNT_W'(DIGITS);
      end
      B_DIGIT: begin
        if (shift_digit) begin
          bcd  <= {bcd[BCD_W-5:0], 4'd0};
          dcnt <= dcnt - DCNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
// Values are fed on the slave stream from a queue filled by the stimulus
// process. Each accepted value is turned into its expected character run by
// a predictor in this file. Every character transfer on the master stream
// is checked against the oldest expected character. Both sides idle in
// random bursts. One long sink stall lets the converter fill up and back
// pressure its input. The sender also pauses until all text has drained.
// The final part runs with no idling at all.
module tb_top;
  import sitoa_pkg::*;

  localparam int RADIX         = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_ITEMS   = 50;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } text_char_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;

  value_t     pending_values[$];
  text_char_t expected_text[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_gap_left    = 0;
  int unsigned rx_gap_left    = 0;
  int unsigned hold_left      = 0;
  int unsigned tx_idle_pct    = 10;
  int unsigned rx_idle_pct    = 10;
  bit          hold_req       = 1'b0;
  bit          hold_taken     = 1'b0;
  bit          calm           = 1'b0;

  signed_int_to_decimal_ascii_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected text of one value: optional sign, then digits with no
  // leading zeros, the last digit flagged.
  function automatic void append_decimal_text(value_t v);
    logic [63:0] mag;
    logic [7:0]  digs[$];
    text_char_t  c;
    bit          neg;
    neg = v[VALUE_WIDTH-1];
    mag = 64'(neg ? value_t'(-v) : v);
    do begin
      digs.push_front(DIGIT_ZERO + 8'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (neg) begin
      c.code    = MINUS_SIGN;
      c.is_last = 1'b0;
      expected_text.push_back(c);
    end
    foreach (digs[i]) begin
      c.code    = digs[i];
      c.is_last = (i == digs.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic value_t rand_value();
    value_t      v;
    logic [63:0] p;
    v = value_t'({$urandom(), $urandom()});
    case ($urandom_range(5))
      0: ;
      1: begin
        v = value_t'($urandom_range(0, 20));
        if ($urandom_range(1)) v = -v;
      end
      2: v = v >> $urandom_range(0, VALUE_WIDTH - 1);
      3: begin
        // Around a power of ten, where the digit count changes.
        p = 64'd1;
        repeat ($urandom_range(0, DIGITS - 1)) p = p * RADIX;
        v = value_t'(p + $urandom_range(0, 2) - 1);
        if ($urandom_range(1)) v = -v;
      end
      4: begin
        if ($urandom_range(1))
          v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + value_t'($urandom_range(0, 3));
        else
          v = {1'b0, {(VALUE_WIDTH-1){1'b1}}} - value_t'($urandom_range(0, 3));
      end
      default: v[VALUE_WIDTH-1] = 1'b1;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sender: one value per transfer, with random gaps between offers.
  always @(posedge clk) begin : drive_values
    bit offer_now;
    if (rst) begin
      s_tvalid    <= 1'b0;
      tx_gap_left <= 0;
    end else begin
      offer_now = s_tvalid;
      if (s_tvalid && s_tready) begin
        append_decimal_text(s_tdata[VALUE_WIDTH-1:0]);
        offer_now = 1'b0;
      end
      if (!offer_now) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
        end else if (pending_values.size() != 0) begin
          if (!calm && $urandom_range(99) < tx_idle_pct) begin
            tx_gap_left <= $urandom_range(1, 15) - 1;
          end else begin
            s_tdata   <= TDATA_W'(pending_values.pop_front());
            offer_now = 1'b1;
          end
        end
      end
      s_tvalid <= offer_now;
    end
  end

  // Sink ready: one long stall on request, otherwise random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      rx_gap_left <= 0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      m_tready   <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left <= rx_gap_left - 1;
      m_tready    <= 1'b0;
    end else if (!calm && $urandom_range(99) < rx_idle_pct) begin
      rx_gap_left <= $urandom_range(1, 15) - 1;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", m_tdata, m_tlast));
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.code)
          report_mismatch($sformatf("character %h, expected %h", m_tdata, want.code));
        if (m_tlast !== want.is_last)
          report_mismatch($sformatf("tlast %b, expected %b on %h",
                                    m_tlast, want.is_last, want.code));
      end
    end
  end

  initial begin
    value_t directed[$];
    directed = '{value_t'(0), value_t'(1), -value_t'(1), value_t'(9), value_t'(10),
                 -value_t'(10), value_t'(99), value_t'(100), value_t'(7), -value_t'(9),
                 {1'b0, {(VALUE_WIDTH-1){1'b1}}}, {1'b1, {(VALUE_WIDTH-1){1'b0}}},
                 {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1},
                 value_t'(64'd1000000000), value_t'(64'd999999999),
                 -value_t'(64'd999999999), value_t'(64'd1234567890),
                 -value_t'(64'd1234567890), {(VALUE_WIDTH/2){2'b01}},
                 {(VALUE_WIDTH/2){2'b10}}, {VALUE_WIDTH{1'b1}}};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) pending_values.push_back(directed[i]);
    // Sender pause: nothing more is offered until every character is out.
    while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0)
      @(negedge clk);

    // Long sink stall while the sender keeps offering.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (12) pending_values.push_back(rand_value());
    while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0)
      @(negedge clk);

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case ($urandom_range(3))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 5;
        2:       tx_idle_pct = 20;
        default: tx_idle_pct = 50;
      endcase
      case ($urandom_range(3))
        0:       rx_idle_pct = 0;
        1:       rx_idle_pct = 5;
        2:       rx_idle_pct = 20;
        default: rx_idle_pct = 50;
      endcase
      repeat (BLOCK_ITEMS) pending_values.push_back(rand_value());
      while (pending_values.size() != 0) @(negedge clk);
    end

    calm = 1'b1;
    // Let any idle burst still in progress run out before the final part.
    while (rx_gap_left != 0 || tx_gap_left != 0) @(negedge clk);
    repeat (40) pending_values.push_back(rand_value());
    while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/sitoa_pkg.sv
hdl/sitoa_front.sv
hdl/sitoa_queue.sv
hdl/sitoa_back.sv
hdl/signed_int_to_decimal_ascii_top.sv
verif/tb_top.sv
